### hdl/mrc_pkg.sv
// shared types, codes and the byte-wide crc update for the response checker
package mrc_pkg;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_EOF  = 1'b1;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_EXP_FUNC  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ERR_LIMIT = 2'd1;

  localparam logic [7:0]  EXP_FUNC_RST  = 8'h03;
  localparam logic [7:0]  ERR_LIMIT_RST = 8'd50;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY      = 16'hA001;
  localparam logic [7:0]  CNT_MAX       = 8'hFF;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_MISMATCH = 2'd1,
    ST_SHORT    = 2'd2
  } status_e;

  // summary of the frame collected so far
  typedef struct packed {
    logic        is_long;
    logic        match;
    logic [15:0] rcv;
    logic [15:0] cmp;
    logic [8:0]  count;
  } frame_sum_t;

  // reflected crc-16, one byte, unrolled over eight bit steps
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

### hdl/modbus_rtu_response_checker.sv
// top level: modbus rtu response crc and function check with link health
//
//  channel | direction | handshake            | word
//  in      | sink      | in_valid_i/in_stall_o | item_kind_i, rx_byte_i
//  out     | source    | out_valid_o/out_stall_i | status, count, checks, link_failed
//  cfg     | sink      | cfg_we_i             | cfg_idx_i, cfg_wdata_i
//
//  one word per cycle unless an end-of-frame word waits on a stalled result:
//  input register, then the crc byte update and frame check into the result register.
//  data bytes never produce a result; an end-of-frame word produces one.
//  reset clears the frame state, counters, fail flag and loads register defaults.
//  a stalled result holds only end-of-frame words; data bytes keep flowing.
module modbus_rtu_response_checker #(
  parameter int unsigned MAX_FRAME_BYTES = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          item_kind_i,
  input  logic [7:0]                    rx_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    frame_status_o,
  output logic [8:0]                    byte_count_o,
  output logic [15:0]                   received_check_o,
  output logic [15:0]                   computed_check_o,
  output logic                          link_failed_o,
  input  logic                          cfg_we_i,
  input  logic [mrc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [7:0]                    cfg_wdata_i
);
  import mrc_pkg::*;

  logic [7:0] exp_func_val_q;
  logic [7:0] err_limit_q;

  logic       in_valid_q;
  logic       kind_q;
  logic [7:0] byte_q;
  logic       advance;
  logic       in_fire;
  logic       byte_fire;
  logic       eof_fire;
  logic       out_free;

  frame_sum_t sum;
  status_e    status;
  logic       fail_next;

  logic       out_valid_q;
  logic [1:0] status_q;
  logic [8:0] count_q;
  logic [15:0] rcv_q;
  logic [15:0] cmp_q;
  logic       fail_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_func_val_q <= EXP_FUNC_RST;
      err_limit_q    <= ERR_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_EXP_FUNC:  exp_func_val_q <= cfg_wdata_i;
        REG_ERR_LIMIT: err_limit_q    <= cfg_wdata_i;
        default: begin
          err_limit_q <= err_limit_q;
        end
      endcase
    end
  end

  // end-of-frame words wait for room in the result register
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && ((kind_q == KIND_DATA) || out_free);
  assign in_stall_o = in_valid_q && !advance;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign byte_fire  = advance && (kind_q == KIND_DATA);
  assign eof_fire   = advance && (kind_q == KIND_EOF);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_fire) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      kind_q <= item_kind_i;
      byte_q <= rx_byte_i;
    end
  end

  mrc_frame_acc #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_frame_acc (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .byte_fire_i(byte_fire),
    .byte_i     (byte_q),
    .eof_fire_i (eof_fire),
    .exp_func_i (exp_func_val_q),
    .sum_o      (sum)
  );

  always_comb begin
    if (!sum.is_long) begin
      status = ST_SHORT;
    end else if (sum.match) begin
      status = ST_OK;
    end else begin
      status = ST_MISMATCH;
    end
  end

  mrc_link_mon u_link_mon (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .eof_fire_i (eof_fire),
    .status_i   (status),
    .err_limit_i(err_limit_q),
    .fail_next_o(fail_next)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (eof_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (eof_fire) begin
      status_q <= status;
      count_q  <= sum.count;
      rcv_q    <= sum.rcv;
      cmp_q    <= sum.cmp;
      fail_q   <= fail_next;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign frame_status_o   = status_q;
  assign byte_count_o     = count_q;
  assign received_check_o = rcv_q;
  assign computed_check_o = cmp_q;
  assign link_failed_o    = fail_q;

  a_eof_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eof_fire |=> out_valid_o)
    else $error("end of frame gave no result");

  a_short_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_status_o == ST_SHORT) |->
      (received_check_o == 16'h0000) && (computed_check_o == 16'h0000))
    else $error("short frame carries check values");

  a_ok_equal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_status_o == ST_OK) |-> (received_check_o == computed_check_o))
    else $error("ok frame with differing checks");

endmodule

### hdl/mrc_frame_acc.sv
// frame accumulator: running crc, two-byte hold line, length and function byte
module mrc_frame_acc #(
  parameter int unsigned MAX_FRAME_BYTES = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               byte_fire_i,
  input  logic [7:0]         byte_i,
  input  logic               eof_fire_i,
  input  logic [7:0]         exp_func_i,
  output mrc_pkg::frame_sum_t sum_o
);
  import mrc_pkg::*;

  localparam int unsigned LEN_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_FRAME_BYTES);

  logic [15:0]      crc_q, crc_d;
  logic [15:0]      held_q, held_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [7:0]       func_q, func_d;
  logic [31:0]      len_ext;

  always_comb begin
    crc_d  = crc_q;
    held_d = held_q;
    len_d  = len_q;
    func_d = func_q;
    if (eof_fire_i) begin
      crc_d  = CRC_INIT;
      held_d = '0;
      len_d  = '0;
      func_d = '0;
    end else if (byte_fire_i && (len_q < LEN_MAX)) begin
      // oldest held byte leaves the hold line into the crc
      if (len_q >= LEN_W'(2)) begin
        crc_d = crc_feed(crc_q, held_q[7:0]);
      end
      if (len_q == LEN_W'(1)) begin
        func_d = byte_i;
      end
      held_d = {byte_i, held_q[15:8]};
      len_d  = len_q + LEN_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q  <= CRC_INIT;
      held_q <= '0;
      len_q  <= '0;
      func_q <= '0;
    end else begin
      crc_q  <= crc_d;
      held_q <= held_d;
      len_q  <= len_d;
      func_q <= func_d;
    end
  end

  assign len_ext       = 32'(len_q);
  assign sum_o.is_long = len_q > LEN_W'(2);
  assign sum_o.match   = (held_q == crc_q) && (func_q == exp_func_i);
  assign sum_o.rcv     = sum_o.is_long ? held_q : 16'h0000;
  assign sum_o.cmp     = sum_o.is_long ? crc_q : 16'h0000;
  assign sum_o.count   = len_ext[8:0];

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LEN_MAX)
    else $error("frame length past maximum");

  a_eof_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eof_fire_i |=> (len_q == '0) && (crc_q == CRC_INIT))
    else $error("frame state not restarted after end of frame");

endmodule

### hdl/mrc_link_mon.sv
// link health: saturating failure counters and the sticky fail flag
module mrc_link_mon (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             eof_fire_i,
  input  mrc_pkg::status_e status_i,
  input  logic [7:0]       err_limit_i,
  output logic             fail_next_o
);
  import mrc_pkg::*;

  logic [7:0] bad_q, bad_d;
  logic [7:0] silent_q, silent_d;
  logic       fail_q;
  logic       fail_set;

  always_comb begin
    bad_d    = bad_q;
    silent_d = silent_q;
    fail_set = 1'b0;
    case (status_i)
      ST_OK: begin
        bad_d    = '0;
        silent_d = '0;
      end
      ST_MISMATCH: begin
        if (bad_q != CNT_MAX) begin
          bad_d = bad_q + 8'd1;
        end
        fail_set = bad_d >= err_limit_i;
      end
      ST_SHORT: begin
        if (silent_q != CNT_MAX) begin
          silent_d = silent_q + 8'd1;
        end
        fail_set = silent_d >= err_limit_i;
      end
      default: begin
        bad_d    = bad_q;
        silent_d = silent_q;
      end
    endcase
  end

  assign fail_next_o = fail_q | fail_set;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bad_q    <= '0;
      silent_q <= '0;
      fail_q   <= 1'b0;
    end else if (eof_fire_i) begin
      bad_q    <= bad_d;
      silent_q <= silent_d;
      fail_q   <= fail_next_o;
    end
  end

  a_fail_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fail_q |=> fail_q)
    else $error("fail flag dropped");

  a_ok_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (eof_fire_i && status_i == ST_OK) |=> (bad_q == '0) && (silent_q == '0))
    else $error("ok frame did not clear counters");

endmodule
